// ----- rtl/core/ihc_pkg.sv -----
package ihc_pkg;

	typedef enum logic [2:0] {
		VERD_PASS   = 3'd0,
		VERD_ETYPE  = 3'd1,
		VERD_VERIHL = 3'd2,
		VERD_TOTLEN = 3'd3,
		VERD_CSUM   = 3'd4,
		VERD_TRUNC  = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [15:0] frame_word;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		verdict_t verdict;
		logic     frame_done;
	} out_item_t;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [5:0]  ETHERTYPE_POS  = 6'd6;
	localparam logic [5:0]  IP_FIRST_POS   = 6'd7;
	localparam logic [5:0]  IP_TOTLEN_POS  = 6'd8;
	localparam logic [5:0]  POS_MAX        = 6'd63;
	localparam logic [3:0]  IP_VERSION     = 4'd4;
	localparam logic [3:0]  IHL_MIN        = 4'd5;
	localparam logic [15:0] CSUM_GOOD      = 16'hFFFF;

endpackage

// ----- rtl/core/ihc_front.sv -----
module ihc_front
	import ihc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_item_t  item,
	output logic      verdict_push,
	output out_item_t verdict_item
);

	logic [5:0]  pos_q;
	logic [15:0] sum_q;
	logic [3:0]  ihl_q;
	verdict_t    err_q;

	logic [15:0] w;
	logic [3:0]  ihl_n;
	logic [5:0]  hdr_end;
	logic        in_hdr;
	logic [16:0] sum_raw;
	logic [15:0] sum_n;
	logic [5:0]  pos_n;
	verdict_t    err_n;
	verdict_t    verdict;

	assign w = item.frame_word;

	always_comb begin
		ihl_n = (pos_q == IP_FIRST_POS) ? w[11:8] : ihl_q;
		hdr_end = {1'b0, ihl_n, 1'b0} + ETHERTYPE_POS;
		in_hdr = (pos_q >= IP_FIRST_POS) && (pos_q <= hdr_end);
		sum_raw = {1'b0, sum_q} + {1'b0, w};
		// End-around carry folds the 17-bit sum back into 16 bits.
		sum_n = in_hdr ? (sum_raw[15:0] + {15'd0, sum_raw[16]}) : sum_q;
		pos_n = (pos_q < POS_MAX) ? pos_q + 6'd1 : pos_q;

		// The first failing check sticks; later ones only apply while no error is held.
		err_n = err_q;
		if (err_n == VERD_PASS && pos_q == ETHERTYPE_POS && w != ETHERTYPE_IPV4) begin
			err_n = VERD_ETYPE;
		end
		if (err_n == VERD_PASS && pos_q == IP_FIRST_POS &&
				(w[15:12] != IP_VERSION || w[11:8] < IHL_MIN)) begin
			err_n = VERD_VERIHL;
		end
		if (err_n == VERD_PASS && pos_q == IP_TOTLEN_POS &&
				{10'd0, ihl_q, 2'b00} > w) begin
			err_n = VERD_TOTLEN;
		end
		if (err_n == VERD_PASS && in_hdr && pos_q == hdr_end && sum_n != CSUM_GOOD) begin
			err_n = VERD_CSUM;
		end

		if (err_n != VERD_PASS) begin
			verdict = err_n;
		end else if (pos_q < IP_FIRST_POS || pos_q < hdr_end) begin
			verdict = VERD_TRUNC;
		end else begin
			verdict = VERD_PASS;
		end
	end

	assign verdict_push = accept && item.last_word;
	assign verdict_item.verdict = verdict;
	assign verdict_item.frame_done = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			ihl_q <= '0;
			err_q <= VERD_PASS;
		end else if (accept) begin
			if (item.last_word) begin
				pos_q <= '0;
				sum_q <= '0;
				ihl_q <= '0;
				err_q <= VERD_PASS;
			end else begin
				pos_q <= pos_n;
				sum_q <= sum_n;
				ihl_q <= ihl_n;
				err_q <= err_n;
			end
		end
	end

endmodule

// ----- rtl/core/ihc_queue.sv -----
module ihc_queue
	import ihc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  out_item_t wr_data,
	input  logic      rd_en,
	output out_item_t rd_data,
	output logic      q_empty,
	output logic      q_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	out_item_t       mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	out_item_t       rd_data_q;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == CW'(DEPTH));
	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	// Pointers wrap at DEPTH, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/core/ihc_back.sv -----
module ihc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  logic pop,
	output logic q_rd_en,
	output logic empty
);

	logic valid_q;

	// The output register is refilled from the queue whenever it is free or being drained.
	assign q_rd_en = !q_empty && (!valid_q || pop);
	assign empty   = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd_en) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/ipv4_header_checker.sv -----
// Verdicts are queued on last words, then enter the output register when it is free.
// Throughput: one word per cycle while full is low; words are handled as they arrive.
// full rises only when DEPTH verdicts wait in the queue in front of the output register.
// Reset (arst_n low) clears the frame state, the verdict queue and the output register.
module ipv4_header_checker
	import ihc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic      accept;
	logic      verdict_push;
	out_item_t verdict_item;
	logic      q_empty;
	logic      q_full;
	logic      q_rd_en;

	assign full   = q_full;
	assign accept = push && !q_full;

	ihc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.verdict_push (verdict_push),
		.verdict_item (verdict_item)
	);

	ihc_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (verdict_push),
		.wr_data (verdict_item),
		.rd_en   (q_rd_en),
		.rd_data (result),
		.q_empty (q_empty),
		.q_full  (q_full)
	);

	ihc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.pop     (pop),
		.q_rd_en (q_rd_en),
		.empty   (empty)
	);

endmodule

// ----- rtl/core/ihc_checker.sv -----
module ihc_checker
	import ihc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input in_item_t  item,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	a_done_set: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.frame_done)
		else $error("result shown without frame_done");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.verdict <= VERD_TRUNC))
		else $error("verdict code out of range");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before transfer");

	a_verdict_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && item.last_word) |=> ##1 !empty)
		else $error("no verdict two cycles after a last word");

endmodule

bind ipv4_header_checker ihc_checker u_ihc_checker (.*);

// ----- bench/ipv4_header_checker_chk.sv -----
`timescale 1ns / 1ps

module ipv4_header_checker_chk
	import ihc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      full,
	input  in_item_t  item,
	input  logic      empty,
	input  logic      pop,
	input  out_item_t result,
	output int        mismatches,
	output int        outstanding,
	output int        checked
);

	// Frame state as seen from the word stream.
	logic [5:0]  word_idx;
	logic [15:0] hdr_sum;
	logic [3:0]  hdr_len;
	verdict_t    first_bad;

	out_item_t   verdicts_due[$];
	out_item_t   want;
	int          bad_n;
	int          checked_n;

	function automatic logic [15:0] ones_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + 16'(s[16]);
	endfunction

	function automatic void note_fail(input verdict_t code);
		if (first_bad == VERD_PASS) begin
			first_bad = code;
		end
	endfunction

	function automatic void clear_frame();
		word_idx  = '0;
		hdr_sum   = '0;
		hdr_len   = '0;
		first_bad = VERD_PASS;
	endfunction

	// Advances the frame state by one word and queues a verdict on the last word.
	function automatic void advance_frame(input in_item_t it);
		logic [5:0] at;
		logic [5:0] hdr_last;
		verdict_t   v;
		at = word_idx;
		if (at == ETHERTYPE_POS) begin
			if (it.frame_word != ETHERTYPE_IPV4) begin
				note_fail(VERD_ETYPE);
			end
		end else if (at == IP_FIRST_POS) begin
			hdr_len = it.frame_word[11:8];
			if (it.frame_word[15:12] != IP_VERSION || hdr_len < IHL_MIN) begin
				note_fail(VERD_VERIHL);
			end
		end else if (at == IP_TOTLEN_POS) begin
			if (first_bad == VERD_PASS && 16'({hdr_len, 2'b00}) > it.frame_word) begin
				note_fail(VERD_TOTLEN);
			end
		end
		hdr_last = ETHERTYPE_POS + {1'b0, hdr_len, 1'b0};
		if (at >= IP_FIRST_POS && at <= hdr_last) begin
			hdr_sum = ones_add16(hdr_sum, it.frame_word);
			if (at == hdr_last && first_bad == VERD_PASS && hdr_sum != CSUM_GOOD) begin
				note_fail(VERD_CSUM);
			end
		end
		if (word_idx != POS_MAX) begin
			word_idx = word_idx + 6'd1;
		end
		if (it.last_word) begin
			if (first_bad != VERD_PASS) begin
				v = first_bad;
			end else if (at < IP_FIRST_POS || at < hdr_last) begin
				v = VERD_TRUNC;
			end else begin
				v = VERD_PASS;
			end
			verdicts_due.push_back('{verdict: v, frame_done: 1'b1});
			clear_frame();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			verdicts_due.delete();
			bad_n = 0;
			checked_n = 0;
			mismatches <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			if (pop && !empty) begin
				checked_n++;
				if (verdicts_due.size() == 0) begin
					bad_n++;
					if (bad_n <= 10) begin
						$display("%0t: verdict %0d/%b transferred with no frame pending",
							$time, result.verdict, result.frame_done);
					end
				end else begin
					want = verdicts_due.pop_front();
					if (result.verdict !== want.verdict || result.frame_done !== want.frame_done) begin
						bad_n++;
						if (bad_n <= 10) begin
							$display("%0t: verdict mismatch: expected %0d (%s) done %b, got %0d done %b",
								$time, want.verdict, want.verdict.name(), want.frame_done,
								result.verdict, result.frame_done);
						end
					end
				end
			end
			if (push && !full) begin
				advance_frame(item);
			end
			mismatches <= bad_n;
			outstanding <= verdicts_due.size();
			checked <= checked_n;
		end
	end

endmodule

// ----- bench/ipv4_header_checker_tb.sv -----
`timescale 1ns / 1ps

module ipv4_header_checker_tb;
	import ihc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	int mismatches;
	int outstanding;
	int checked;

	logic [15:0] frame_q[$];
	int          words_sent;
	int          frames_sent;
	bit          hold_rx;

	ipv4_header_checker uut (
		.clk, .arst_n, .push, .full, .item, .empty, .pop, .result
	);

	ipv4_header_checker_chk chk (
		.clk, .arst_n, .push, .full, .item, .empty, .pop, .result,
		.mismatches, .outstanding, .checked
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout: %0d verdicts still pending", outstanding);
		$display("end of test: mismatches");
		$finish;
	end

	// Result side: random pops, short and long stalls, eager stretches, and a
	// long hold-off on request.
	initial begin
		int stall;
		int r;
		bit eager;
		stall = 0;
		eager = 1'b0;
		pop <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				hold_rx = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				if ($urandom_range(149) == 0) begin
					eager = !eager;
				end
				r = $urandom_range(99);
				if (eager) begin
					pop <= 1'b1;
				end else if (r < 3) begin
					pop <= 1'b0;
					stall = $urandom_range(40, 10);
				end else begin
					pop <= (r < 75);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	// Builds an Ethernet frame with an IPv4 header into frame_q, with the
	// requested faults applied.
	function automatic void build_frame(input bit bad_etype, input bit bad_ver,
			input bit bad_ihl, input bit short_len, input bit bad_csum,
			input int ihl, input int payload);
		logic [15:0] hdr[$];
		logic [15:0] etype;
		logic [3:0]  ver;
		int          lim;
		int          tl;
		int          nw;
		int          acc;
		int          r;
		frame_q.delete();
		repeat (6) frame_q.push_back(16'($urandom));
		etype = ETHERTYPE_IPV4;
		if (bad_etype) begin
			do begin
				etype = ($urandom_range(3) == 0) ? 16'h86DD : 16'($urandom);
			end while (etype == ETHERTYPE_IPV4);
		end
		frame_q.push_back(etype);
		ver = IP_VERSION;
		if (bad_ver) begin
			do begin
				ver = 4'($urandom);
			end while (ver == IP_VERSION);
		end
		if (bad_ihl) begin
			ihl = $urandom_range(4, 0);
		end
		hdr.push_back({ver, 4'(ihl), 8'($urandom)});
		lim = 4 * ihl;
		if (short_len && lim > 0) begin
			tl = $urandom_range(1) ? lim - 1 : $urandom_range(lim - 1, 0);
		end else begin
			r = $urandom_range(7);
			tl = (r == 0) ? lim : (r == 1) ? 65535 : $urandom_range(65535, lim);
		end
		hdr.push_back(16'(tl));
		nw = 2 * ((ihl < 5) ? 5 : ihl);
		for (int i = 2; i < nw; i++) begin
			hdr.push_back((i == 5) ? 16'h0000 : 16'($urandom));
		end
		acc = 0;
		foreach (hdr[i]) begin
			acc += hdr[i];
		end
		acc = (acc & 32'hFFFF) + (acc >> 16);
		acc = (acc & 32'hFFFF) + (acc >> 16);
		hdr[5] = ~acc[15:0];
		if (bad_csum) begin
			hdr[5] ^= 16'($urandom_range(65535, 1));
		end
		foreach (hdr[i]) begin
			frame_q.push_back(hdr[i]);
		end
		repeat (payload) frame_q.push_back(16'($urandom));
	endfunction

	// Ends the frame somewhere before its last header word.
	function automatic void cut_frame();
		int hdr_end;
		int len;
		hdr_end = 6 + 2 * frame_q[7][11:8];
		if (hdr_end < 7) begin
			hdr_end = 7;
		end
		len = $urandom_range(hdr_end, 1);
		frame_q = frame_q[0:len-1];
	endfunction

	task automatic put_word(input logic [15:0] w, input logic lst);
		item <= '{frame_word: w, last_word: lst};
		push <= 1'b1;
		do @(posedge clk); while (full);
		words_sent++;
	endtask

	task automatic idle_gap();
		int n;
		n = pick_gap();
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_frame(input bit tight);
		for (int i = 0; i < frame_q.size(); i++) begin
			put_word(frame_q[i], i == frame_q.size() - 1);
			if (!tight) begin
				idle_gap();
			end
		end
		frames_sent++;
	endtask

	// Stops offering words until every verdict has been transferred.
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// The output is held off while one-word frames keep coming, so the verdict
	// queue fills and full must hold back the input.
	task automatic fill_queue();
		hold_rx = 1'b1;
		repeat (24) begin
			frame_q.delete();
			frame_q.push_back(16'($urandom));
			send_frame(1'b1);
		end
		settle();
	endtask

	initial begin
		int  r;
		int  ihl;
		int  pay;
		bit  pressed;
		arst_n = 1'b0;
		push <= 1'b0;
		item <= '0;
		hold_rx = 1'b0;
		words_sent = 0;
		frames_sent = 0;
		pressed = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames.
		frame_q = {16'hFFFF};
		send_frame(1'b0);
		build_frame(0, 0, 0, 0, 0, 5, 0);
		send_frame(1'b1);
		build_frame(0, 0, 0, 0, 0, 15, 0);
		send_frame(1'b0);
		build_frame(1, 0, 0, 0, 0, 5, 2);
		send_frame(1'b0);
		build_frame(0, 1, 0, 0, 0, 5, 1);
		send_frame(1'b0);
		build_frame(0, 0, 1, 0, 0, 5, 0);
		send_frame(1'b0);
		build_frame(0, 0, 0, 1, 0, 6, 1);
		send_frame(1'b0);
		build_frame(0, 0, 0, 0, 1, 5, 3);
		send_frame(1'b0);
		// First failure wins over later ones.
		build_frame(1, 0, 0, 1, 1, 5, 0);
		send_frame(1'b0);
		build_frame(0, 1, 0, 1, 1, 7, 0);
		send_frame(1'b0);
		build_frame(0, 0, 0, 0, 0, 5, 0);
		frame_q = frame_q[0:11];
		send_frame(1'b0);
		build_frame(0, 0, 0, 0, 0, 5, 0);
		frame_q = frame_q[0:4];
		send_frame(1'b0);
		// Long enough for the word position to saturate.
		build_frame(0, 0, 0, 0, 0, 10, 80);
		send_frame(1'b0);
		frame_q = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000};
		send_frame(1'b1);

		// Random frames, mostly well formed.
		while (words_sent < 800 || frames_sent < 50) begin
			r = $urandom_range(99);
			ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
			pay = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 0);
			if (r < 8) begin
				frame_q.delete();
				repeat ($urandom_range(24, 1)) frame_q.push_back(16'($urandom));
				if (r < 4 && frame_q.size() > 6) begin
					frame_q[6] = ETHERTYPE_IPV4;
				end
			end else begin
				build_frame($urandom_range(9) == 0, $urandom_range(9) == 0,
					$urandom_range(9) == 0, $urandom_range(9) == 0,
					$urandom_range(7) == 0, ihl, pay);
				if (r < 22) begin
					cut_frame();
				end
			end
			send_frame($urandom_range(4) == 0);
			if (!pressed && frames_sent >= 30) begin
				pressed = 1'b1;
				fill_queue();
			end
		end

		settle();
		repeat (20) @(posedge clk);
		$display("%0d frame words in %0d frames, %0d verdicts checked", words_sent,
			frames_sent, checked);
		$display("covered every verdict code, short and long frames, and a full output queue");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
